### sv/spoar_pkg.sv
package spoar_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DRIVE_LIMITS     = 3'd0;
  localparam logic [2:0] CFG_UPPER_LEVELS     = 3'd1;
  localparam logic [2:0] CFG_LOWER_LEVELS     = 3'd2;
  localparam logic [2:0] CFG_HYSTERESIS       = 3'd3;
  localparam logic [2:0] CFG_SEVERITIES       = 3'd4;
  localparam logic [2:0] CFG_DEADBANDS        = 3'd5;
  localparam logic [2:0] CFG_OUTPUT_OPTIONS   = 3'd6;
  localparam logic [2:0] CFG_INVALID_VALUE    = 3'd7;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 64;

  // Write option codes.
  localparam logic [2:0] WOPT_EVERY        = 3'd0;
  localparam logic [2:0] WOPT_ON_CHANGE    = 3'd1;
  localparam logic [2:0] WOPT_WHEN_ZERO    = 3'd2;
  localparam logic [2:0] WOPT_WHEN_NONZERO = 3'd3;
  localparam logic [2:0] WOPT_TO_ZERO      = 3'd4;
  localparam logic [2:0] WOPT_TO_NONZERO   = 3'd5;

  // Invalid output action codes.
  localparam logic [1:0] ACT_CONTINUE   = 2'd0;
  localparam logic [1:0] ACT_NO_DRIVE   = 2'd1;
  localparam logic [1:0] ACT_SUBSTITUTE = 2'd2;

  // Severity codes.
  localparam logic [1:0] SEV_NONE    = 2'd0;
  localparam logic [1:0] SEV_INVALID = 2'd3;

  // Reset value of the output options register: write on change.
  localparam logic [4:0] OutputOptionsReset = 5'd1;

  typedef enum logic [2:0] {
    ALM_NONE  = 3'd0,
    ALM_UNDEF = 3'd1,
    ALM_HIHI  = 3'd2,
    ALM_LOLO  = 3'd3,
    ALM_HIGH  = 3'd4,
    ALM_LOW   = 3'd5
  } alarm_status_t;

  typedef struct packed {
    logic [63:0] drive_limits;
    logic [63:0] upper_alarm_levels;
    logic [63:0] lower_alarm_levels;
    logic [30:0] hysteresis;
    logic [9:0]  alarm_severities;
    logic [63:0] monitor_deadbands;
    logic [4:0]  output_options;
    logic [31:0] invalid_output_value;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] requested_value;
    logic        value_good;
  } in_item_t;

  typedef struct packed {
    logic          do_write;
    logic [31:0]   drive_value;
    alarm_status_t alarm_status;
    logic [1:0]    alarm_severity;
    logic          alarm_changed;
    logic          value_event;
    logic          archive_event;
  } out_item_t;

  typedef struct packed {
    logic [31:0]   current_value;
    logic          value_defined;
    logic [31:0]   last_alarm_level;
    logic [31:0]   last_monitored;
    logic [31:0]   last_archived;
    logic [31:0]   previous_output;
    logic          force_write;
    logic [1:0]    last_severity;
    alarm_status_t last_status;
  } state_t;

endpackage

### sv/spoar_alarm.sv
module spoar_alarm (
  input  spoar_pkg::cfg_t          cfg,
  input  logic                     value_defined,
  input  logic [31:0]              value,
  input  logic [31:0]              last_level,
  output logic [1:0]               severity,
  output spoar_pkg::alarm_status_t status,
  output logic [31:0]              last_level_next
);
  import spoar_pkg::*;

  localparam alarm_status_t LevelCode [4] = '{ALM_HIHI, ALM_LOLO, ALM_HIGH, ALM_LOW};

  logic [31:0]        level [4];
  logic [1:0]         level_sev [4];
  logic [3:0]         hit;
  logic signed [33:0] val_x;
  logic signed [33:0] last_x;
  logic signed [33:0] hyst_x;

  // Levels in checking order: hihi, lolo, high, low.
  assign level[0] = cfg.upper_alarm_levels[63:32];
  assign level[1] = cfg.lower_alarm_levels[31:0];
  assign level[2] = cfg.upper_alarm_levels[31:0];
  assign level[3] = cfg.lower_alarm_levels[63:32];

  assign val_x  = {{2{value[31]}}, value};
  assign last_x = {{2{last_level[31]}}, last_level};
  assign hyst_x = {3'b000, cfg.hysteresis};

  // Each level is compared on its own; a level still active may hold within
  // the hysteresis margin. Sums are wide enough that they never wrap.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [33:0] lev_x;
      lev_x = {{2{level[i][31]}}, level[i]};
      level_sev[i] = cfg.alarm_severities[2*i +: 2];
      if ((i % 2) == 0) begin
        hit[i] = (val_x >= lev_x) || ((last_x == lev_x) && (val_x >= lev_x - hyst_x));
      end else begin
        hit[i] = (val_x <= lev_x) || ((last_x == lev_x) && (val_x <= lev_x + hyst_x));
      end
    end
  end

  // The first enabled level that is hit wins.
  always_comb begin
    severity        = SEV_NONE;
    status          = ALM_NONE;
    last_level_next = last_level;
    if (!value_defined) begin
      severity = cfg.alarm_severities[9:8];
      status   = (severity != SEV_NONE) ? ALM_UNDEF : ALM_NONE;
    end else begin
      last_level_next = value;
      for (int i = 3; i >= 0; i--) begin
        if ((level_sev[i] != SEV_NONE) && hit[i]) begin
          severity        = level_sev[i];
          status          = LevelCode[i];
          last_level_next = level[i];
        end
      end
    end
  end

endmodule

### sv/spoar_core.sv
module spoar_core (
  input  spoar_pkg::cfg_t     cfg,
  input  spoar_pkg::state_t   state,
  input  spoar_pkg::in_item_t item,
  output spoar_pkg::state_t   state_next,
  output spoar_pkg::out_item_t result,
  output logic                has_result
);
  import spoar_pkg::*;

  logic signed [31:0] req_s;
  logic signed [31:0] hi_s;
  logic signed [31:0] lo_s;
  logic [31:0]        clamped;
  logic [31:0]        value_a;
  logic               defined_a;
  logic [1:0]         sev;
  alarm_status_t      sta;
  logic [31:0]        alarm_level_next;
  logic [2:0]         opt;
  logic [1:0]         act;
  logic               drive;
  logic [31:0]        value_out;
  logic               wr;
  logic signed [33:0] val_x;
  logic signed [33:0] mon_diff;
  logic signed [33:0] arc_diff;
  logic signed [33:0] mon_mag;
  logic signed [33:0] arc_mag;
  logic signed [31:0] mon_db;
  logic signed [31:0] arc_db;
  logic               vev;
  logic               aev;

  // Clamp to the drive limits when they are ordered.
  assign req_s = item.requested_value;
  assign hi_s  = cfg.drive_limits[63:32];
  assign lo_s  = cfg.drive_limits[31:0];

  always_comb begin
    clamped = item.requested_value;
    if (hi_s > lo_s) begin
      if (req_s > hi_s) begin
        clamped = hi_s;
      end else if (req_s < lo_s) begin
        clamped = lo_s;
      end
    end
  end

  // A bad value leaves the setpoint as it was.
  assign value_a   = item.value_good ? clamped : state.current_value;
  assign defined_a = item.value_good | state.value_defined;

  spoar_alarm u_alarm (
    .cfg             (cfg),
    .value_defined   (defined_a),
    .value           (value_a),
    .last_level      (state.last_alarm_level),
    .severity        (sev),
    .status          (sta),
    .last_level_next (alarm_level_next)
  );

  // Invalid output action: block the write or substitute a fixed value.
  assign opt       = cfg.output_options[2:0];
  assign act       = cfg.output_options[4:3];
  assign drive     = (sev != SEV_INVALID) || (act == ACT_CONTINUE) || (act == ACT_SUBSTITUTE);
  assign value_out = ((sev == SEV_INVALID) && (act == ACT_SUBSTITUTE)) ?
                     cfg.invalid_output_value : value_a;

  // Write option decides whether the device sees this transfer.
  always_comb begin
    case (opt)
      WOPT_EVERY:        wr = 1'b1;
      WOPT_ON_CHANGE:    wr = state.force_write || (value_out != state.previous_output);
      WOPT_WHEN_ZERO:    wr = (value_out == '0);
      WOPT_WHEN_NONZERO: wr = (value_out != '0);
      WOPT_TO_ZERO:      wr = (value_out == '0) && (state.previous_output != '0);
      WOPT_TO_NONZERO:   wr = (value_out != '0) && (state.previous_output == '0);
      default:           wr = 1'b0;
    endcase
  end

  // Monitor deadbands; a negative deadband posts on every process.
  assign val_x    = {{2{value_out[31]}}, value_out};
  assign mon_diff = {{2{state.last_monitored[31]}}, state.last_monitored} - val_x;
  assign arc_diff = {{2{state.last_archived[31]}}, state.last_archived} - val_x;
  assign mon_mag  = mon_diff[33] ? -mon_diff : mon_diff;
  assign arc_mag  = arc_diff[33] ? -arc_diff : arc_diff;
  assign mon_db   = cfg.monitor_deadbands[63:32];
  assign arc_db   = cfg.monitor_deadbands[31:0];
  assign vev      = mon_db[31] || (mon_mag > {{2{mon_db[31]}}, mon_db});
  assign aev      = arc_db[31] || (arc_mag > {{2{arc_db[31]}}, arc_db});

  // Next state and result.
  always_comb begin
    state_next = state;
    has_result = 1'b0;
    result.do_write       = drive && wr;
    result.drive_value    = value_out;
    result.alarm_status   = sta;
    result.alarm_severity = sev;
    result.alarm_changed  = (sev != state.last_severity) || (sta != state.last_status);
    result.value_event    = vev;
    result.archive_event  = aev;
    if (item.kind) begin
      state_next.force_write = 1'b1;
    end else begin
      has_result                 = 1'b1;
      state_next.current_value   = value_out;
      state_next.value_defined   = defined_a;
      state_next.last_alarm_level = alarm_level_next;
      state_next.last_severity   = sev;
      state_next.last_status     = sta;
      if (drive) begin
        state_next.previous_output = value_out;
        state_next.force_write     = 1'b0;
      end
      if (vev) begin
        state_next.last_monitored = value_out;
      end
      if (aev) begin
        state_next.last_archived = value_out;
      end
    end
  end

endmodule

### sv/setpoint_output_alarm_record_top.sv
// Integer setpoint output stage. Each process transfer is clamped to the drive
// limits, checked against four alarm levels with hysteresis, passed through the
// invalid output action and the write option, and tested against the value and
// archive deadbands; it yields one result transfer. A target-changed transfer
// only arms a forced write for the next on-change process and yields no result.
// The block takes one transfer per cycle unless a held result stalls it: an
// input register feeds one pass of compare and select logic that updates the
// record state and loads the output register, so an accepted item passes
// through the input register and then the output register, and an output
// register that is read in the same cycle does not stop the next item from
// being taken. While a held result waits for out_ready, the input register
// holds its process item and in_ready stays low. Configuration is written
// through cfg_write, cfg_index and cfg_data; the user must write it only while
// no item is in flight, as the block itself does not enforce this.
module setpoint_output_alarm_record_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spoar_pkg::in_item_t                 in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spoar_pkg::out_item_t                out_item,
  input  logic                                cfg_write,
  input  logic [spoar_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [spoar_pkg::CfgDataWidth-1:0]  cfg_data
);
  import spoar_pkg::*;

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t result;
  logic      has_result;
  logic      fire;

  // The held item goes through when it has nowhere to go or the output slot frees.
  assign fire     = in_valid_q && (in_q.kind || !out_valid || out_ready);
  assign in_ready = !in_valid_q || fire;

  spoar_core u_core (
    .cfg        (cfg),
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .result     (result),
    .has_result (has_result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_limits         <= '0;
      cfg.upper_alarm_levels   <= '0;
      cfg.lower_alarm_levels   <= '0;
      cfg.hysteresis           <= '0;
      cfg.alarm_severities     <= '0;
      cfg.monitor_deadbands    <= '0;
      cfg.output_options       <= OutputOptionsReset;
      cfg.invalid_output_value <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DRIVE_LIMITS:   cfg.drive_limits         <= cfg_data;
        CFG_UPPER_LEVELS:   cfg.upper_alarm_levels   <= cfg_data;
        CFG_LOWER_LEVELS:   cfg.lower_alarm_levels   <= cfg_data;
        CFG_HYSTERESIS:     cfg.hysteresis           <= cfg_data[30:0];
        CFG_SEVERITIES:     cfg.alarm_severities     <= cfg_data[9:0];
        CFG_DEADBANDS:      cfg.monitor_deadbands    <= cfg_data;
        CFG_OUTPUT_OPTIONS: cfg.output_options       <= cfg_data[4:0];
        CFG_INVALID_VALUE:  cfg.invalid_output_value <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  // Record state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.current_value    <= '0;
      state.value_defined    <= 1'b0;
      state.last_alarm_level <= '0;
      state.last_monitored   <= '0;
      state.last_archived    <= '0;
      state.previous_output  <= '0;
      state.force_write      <= 1'b1;
      state.last_severity    <= SEV_NONE;
      state.last_status      <= ALM_NONE;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_item <= result;
    end
  end

  // Severity and status are raised and cleared together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.alarm_severity == SEV_NONE) == (out_item.alarm_status == ALM_NONE)))
    else $error("alarm severity and status disagree");

  // A blocked invalid output never reaches the device.
  assert property (@(posedge clk) disable iff (rst)
    (fire && !in_q.kind && (result.alarm_severity == SEV_INVALID) &&
     (cfg.output_options[4:3] != ACT_CONTINUE) &&
     (cfg.output_options[4:3] != ACT_SUBSTITUTE)) |-> !result.do_write)
    else $error("write issued while invalid action blocks output");

  // A target-changed transfer arms the forced write.
  assert property (@(posedge clk) disable iff (rst)
    (fire && in_q.kind) |=> state.force_write)
    else $error("forced write not armed");

  // A target-changed transfer never loads a result.
  assert property (@(posedge clk) disable iff (rst)
    (fire && in_q.kind && !out_valid) |=> !out_valid)
    else $error("result produced for target-changed transfer");

endmodule

### tb/tb_top.sv
module tb_top;
  import spoar_pkg::*;

  // Item kinds carried in the kind field of an input transfer.
  localparam logic KIND_PROCESS = 1'b0;
  localparam logic KIND_TARGET  = 1'b1;

  localparam int CycleLimit      = 200000;
  localparam int ItemsPerSetting = 36;
  localparam int SettingsPerMode = 6;

  // Tracks the record state and configuration and predicts each result transfer.
  class setpoint_scoreboard;
    cfg_t      cfg;
    state_t    st;
    out_item_t drive_records[$];
    int        errors;
    int        process_items;
    int        target_items;
    int        results_checked;
    int        writes_expected;
    int        alarms_expected;

    function new();
      cfg = '0;
      cfg.output_options = OutputOptionsReset;
      st = '0;
      st.force_write = 1'b1;
      st.last_status = ALM_NONE;
    endfunction

    function longint widen(logic [31:0] w);
      return longint'($signed(w));
    endfunction

    function longint distance(longint a, longint b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void set_register(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_DRIVE_LIMITS:   cfg.drive_limits = data;
        CFG_UPPER_LEVELS:   cfg.upper_alarm_levels = data;
        CFG_LOWER_LEVELS:   cfg.lower_alarm_levels = data;
        CFG_HYSTERESIS:     cfg.hysteresis = data[30:0];
        CFG_SEVERITIES:     cfg.alarm_severities = data[9:0];
        CFG_DEADBANDS:      cfg.monitor_deadbands = data;
        CFG_OUTPUT_OPTIONS: cfg.output_options = data[4:0];
        CFG_INVALID_VALUE:  cfg.invalid_output_value = data[31:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted input transfer and queues it.
    function void predict_record(in_item_t it);
      longint        req, hi, lo, val, lalm, hyst, lvl, mdb, adb;
      longint        levels[4];
      alarm_status_t codes[4];
      logic [1:0]    sev, s;
      alarm_status_t sta;
      logic [2:0]    wopt;
      logic [1:0]    act;
      logic          drive, wr, hit, chg, vev, aev;
      out_item_t     exp;
      codes = '{ALM_HIHI, ALM_LOLO, ALM_HIGH, ALM_LOW};
      if (it.kind == KIND_TARGET) begin
        target_items++;
        st.force_write = 1'b1;
        return;
      end
      process_items++;

      // A good value is clamped only when the drive limits are ordered.
      if (it.value_good) begin
        req = widen(it.requested_value);
        hi = widen(cfg.drive_limits[63:32]);
        lo = widen(cfg.drive_limits[31:0]);
        if (hi > lo) begin
          if (req > hi) req = hi;
          else if (req < lo) req = lo;
        end
        st.current_value = req[31:0];
        st.value_defined = 1'b1;
      end

      // Alarm levels are tried in priority order; hysteresis holds the last level.
      sev = SEV_NONE;
      sta = ALM_NONE;
      if (!st.value_defined) begin
        sev = cfg.alarm_severities[9:8];
        sta = (sev != SEV_NONE) ? ALM_UNDEF : ALM_NONE;
      end else begin
        val = widen(st.current_value);
        lalm = widen(st.last_alarm_level);
        hyst = longint'({1'b0, cfg.hysteresis});
        levels[0] = widen(cfg.upper_alarm_levels[63:32]);
        levels[1] = widen(cfg.lower_alarm_levels[31:0]);
        levels[2] = widen(cfg.upper_alarm_levels[31:0]);
        levels[3] = widen(cfg.lower_alarm_levels[63:32]);
        for (int i = 0; i < 4; i++) begin
          s = cfg.alarm_severities[2*i +: 2];
          lvl = levels[i];
          if (i % 2 == 0) hit = (val >= lvl) || (lalm == lvl && val >= lvl - hyst);
          else hit = (val <= lvl) || (lalm == lvl && val <= lvl + hyst);
          if (sta == ALM_NONE && s != SEV_NONE && hit) begin
            sev = s;
            sta = codes[i];
            st.last_alarm_level = lvl[31:0];
          end
        end
        if (sta == ALM_NONE) st.last_alarm_level = st.current_value;
      end

      // Invalid output action, then the write option.
      wopt = cfg.output_options[2:0];
      act = cfg.output_options[4:3];
      drive = sev != SEV_INVALID || act == ACT_CONTINUE || act == ACT_SUBSTITUTE;
      if (sev == SEV_INVALID && act == ACT_SUBSTITUTE)
        st.current_value = cfg.invalid_output_value;
      wr = 1'b0;
      if (drive) begin
        case (wopt)
          WOPT_EVERY:        wr = 1'b1;
          WOPT_ON_CHANGE:    wr = st.force_write || st.current_value != st.previous_output;
          WOPT_WHEN_ZERO:    wr = st.current_value == '0;
          WOPT_WHEN_NONZERO: wr = st.current_value != '0;
          WOPT_TO_ZERO:      wr = st.current_value == '0 && st.previous_output != '0;
          WOPT_TO_NONZERO:   wr = st.current_value != '0 && st.previous_output == '0;
          default:           wr = 1'b0;
        endcase
        st.previous_output = st.current_value;
        st.force_write = 1'b0;
      end

      chg = sev != st.last_severity || sta != st.last_status;
      st.last_severity = sev;
      st.last_status = sta;

      // Monitor deadbands; a negative deadband flags every process.
      val = widen(st.current_value);
      mdb = widen(cfg.monitor_deadbands[63:32]);
      adb = widen(cfg.monitor_deadbands[31:0]);
      vev = mdb < 0 || distance(widen(st.last_monitored), val) > mdb;
      if (vev) st.last_monitored = st.current_value;
      aev = adb < 0 || distance(widen(st.last_archived), val) > adb;
      if (aev) st.last_archived = st.current_value;

      exp.do_write = wr;
      exp.drive_value = st.current_value;
      exp.alarm_status = sta;
      exp.alarm_severity = sev;
      exp.alarm_changed = chg;
      exp.value_event = vev;
      exp.archive_event = aev;
      if (wr) writes_expected++;
      if (sta != ALM_NONE) alarms_expected++;
      drive_records.push_back(exp);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] g);
      if (g !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_record(out_item_t got);
      out_item_t exp;
      if (drive_records.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %0h",
                 $time, got);
        return;
      end
      exp = drive_records.pop_front();
      results_checked++;
      compare_field("do_write", exp.do_write, got.do_write);
      compare_field("drive_value", exp.drive_value, got.drive_value);
      compare_field("alarm_status", exp.alarm_status, got.alarm_status);
      compare_field("alarm_severity", exp.alarm_severity, got.alarm_severity);
      compare_field("alarm_changed", exp.alarm_changed, got.alarm_changed);
      compare_field("value_event", exp.value_event, got.value_event);
      compare_field("archive_event", exp.archive_event, got.archive_event);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  setpoint_scoreboard sb;
  int          send_idle = 12;
  int          recv_idle = 54;
  int          cycle_count = 0;
  int          settings_applied = 0;
  logic [31:0] last_request = '0;
  cfg_t        plan;

  setpoint_output_alarm_record_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random at the current idle rate.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watches every transfer and register write at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_record(out_item);
      if (in_valid && in_ready) sb.predict_record(in_item);
      if (cfg_write) sb.set_register(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL setpoint_output_alarm_record_top");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic kind, logic [31:0] v, logic good);
    in_item_t it;
    it.kind = kind;
    it.requested_value = v;
    it.value_good = good;
    return it;
  endfunction

  // Mostly values near the limits and alarm levels, with repeats, zeros and noise.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.kind = ($urandom_range(99) < 8) ? KIND_TARGET : KIND_PROCESS;
    it.value_good = ($urandom_range(99) >= 10);
    if (pick < 50) it.requested_value = int'($urandom_range(5000)) - 2500;
    else if (pick < 65) it.requested_value = $urandom;
    else if (pick < 75) it.requested_value = '0;
    else if (pick < 90) it.requested_value = last_request;
    else if (pick < 94) it.requested_value = 32'h7FFF_FFFF;
    else if (pick < 97) it.requested_value = 32'h8000_0000;
    else it.requested_value = 32'hFFFF_FFFF;
    last_request = it.requested_value;
    return it;
  endfunction

  function automatic logic [31:0] random_deadband();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return $urandom_range(300);
    else if (pick < 8) return -int'($urandom_range(1000)) - 1;
    else return $urandom;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    int   hi, lo, hihi, high, low, lolo;
    hi = int'($urandom_range(3000));
    lo = -int'($urandom_range(3000));
    case ($urandom_range(3))
      0: c.drive_limits = {$urandom, $urandom};
      1: c.drive_limits = {lo, hi};
      default: c.drive_limits = {hi, lo};
    endcase
    hihi = int'($urandom_range(2500)) - 500;
    high = hihi - int'($urandom_range(800));
    low = -int'($urandom_range(2000));
    lolo = low - int'($urandom_range(800));
    if ($urandom_range(4) == 0) begin
      c.upper_alarm_levels = {$urandom, $urandom};
      c.lower_alarm_levels = {$urandom, $urandom};
    end else begin
      c.upper_alarm_levels = {hihi, high};
      c.lower_alarm_levels = {low, lolo};
    end
    case ($urandom_range(9))
      7: c.hysteresis = '0;
      8: c.hysteresis = 31'($urandom);
      9: c.hysteresis = '1;
      default: c.hysteresis = 31'($urandom_range(300));
    endcase
    c.alarm_severities = 10'($urandom_range(1023));
    c.monitor_deadbands = {random_deadband(), random_deadband()};
    c.output_options = {2'($urandom_range(3)), 3'($urandom_range(7))};
    c.invalid_output_value = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
    return c;
  endfunction

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender until every predicted result has arrived and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.drive_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_DRIVE_LIMITS, c.drive_limits);
    write_reg(CFG_UPPER_LEVELS, c.upper_alarm_levels);
    write_reg(CFG_LOWER_LEVELS, c.lower_alarm_levels);
    write_reg(CFG_HYSTERESIS, 64'(c.hysteresis));
    write_reg(CFG_SEVERITIES, 64'(c.alarm_severities));
    write_reg(CFG_DEADBANDS, c.monitor_deadbands);
    write_reg(CFG_OUTPUT_OPTIONS, 64'(c.output_options));
    write_reg(CFG_INVALID_VALUE, 64'(c.invalid_output_value));
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a bad value leaves the record undefined with zero severity.
    send_item(make_item(KIND_PROCESS, 32'd123, 1'b0));
    send_item(make_item(KIND_TARGET, 32'd0, 1'b0));
    send_item(make_item(KIND_PROCESS, 32'hFFFF_FFFF, 1'b0));

    // Undefined alarm at invalid severity with substitution, then with the write blocked.
    drain();
    plan = '0;
    plan.alarm_severities = {SEV_INVALID, 8'd0};
    plan.output_options = {ACT_SUBSTITUTE, WOPT_EVERY};
    plan.invalid_output_value = 32'h8000_0000;
    apply_config(plan);
    send_item(make_item(KIND_PROCESS, 32'd7, 1'b0));
    send_item(make_item(KIND_PROCESS, 32'hFFFF_FFFF, 1'b0));
    drain();
    plan.output_options = {ACT_NO_DRIVE, WOPT_ON_CHANGE};
    apply_config(plan);
    send_item(make_item(KIND_PROCESS, 32'd9, 1'b0));
    drain();
    plan.output_options = {2'd3, WOPT_ON_CHANGE};
    apply_config(plan);
    send_item(make_item(KIND_PROCESS, 32'd9, 1'b0));

    // Ordered limits, four levels with hysteresis, small deadbands.
    drain();
    plan.drive_limits = {32'd1000, -32'sd1000};
    plan.upper_alarm_levels = {32'd900, 32'd500};
    plan.lower_alarm_levels = {-32'sd500, -32'sd900};
    plan.hysteresis = 31'd50;
    plan.alarm_severities = {2'd3, 2'd1, 2'd1, 2'd2, 2'd2};
    plan.monitor_deadbands = {32'd10, 32'd100};
    plan.output_options = {ACT_CONTINUE, WOPT_EVERY};
    apply_config(plan);
    send_item(make_item(KIND_TARGET, 32'd0, 1'b0));
    send_item(make_item(KIND_PROCESS, 32'h7FFF_FFFF, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd880, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd840, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'h8000_0000, 1'b1));
    send_item(make_item(KIND_PROCESS, -32'sd870, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd0, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd5, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd600, 1'b1));
    send_item(make_item(KIND_PROCESS, -32'sd600, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd600, 1'b0));

    // Unordered limits, levels at the ends of the range, maximum hysteresis.
    drain();
    plan.drive_limits = {-32'sd5, 32'd5};
    plan.upper_alarm_levels = {32'h7FFF_FFFF, 32'h0000_0000};
    plan.lower_alarm_levels = {32'h0000_0000, 32'h8000_0000};
    plan.hysteresis = '1;
    plan.alarm_severities = {2'd0, 2'd1, 2'd0, 2'd3, 2'd3};
    plan.monitor_deadbands = {32'hFFFF_FFFF, 32'h8000_0000};
    plan.output_options = {ACT_CONTINUE, WOPT_TO_NONZERO};
    apply_config(plan);
    send_item(make_item(KIND_PROCESS, 32'h7FFF_FFFF, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'd0, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'h8000_0000, 1'b1));
    send_item(make_item(KIND_PROCESS, 32'hFFFF_FFFF, 1'b1));

    // Random part: three idle modes, several settings each.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 12 : (mode == 1) ? 54 : 0;
      recv_idle = (mode == 0) ? 54 : (mode == 1) ? 12 : 0;
      for (int k = 0; k < SettingsPerMode; k++) begin
        drain();
        if (mode == 0 && k == 0) plan = '1;
        else if (mode == 1 && k == 0) plan = '0;
        else plan = random_settings();
        apply_config(plan);
        for (int n = 0; n < ItemsPerSetting; n++) begin
          if (n == ItemsPerSetting / 2 && k % 2 == 0) drain();
          send_item(random_item());
        end
      end
    end

    drain();
    repeat (6) @(posedge clk);
    $display("Covered %0d process and %0d target-changed transfers under %0d settings.",
             sb.process_items, sb.target_items, settings_applied);
    $display("Checked %0d results: %0d device writes, %0d with an active alarm.",
             sb.results_checked, sb.writes_expected, sb.alarms_expected);
    if (sb.errors == 0) begin
      $display("PASS setpoint_output_alarm_record_top");
    end else begin
      $display("FAIL setpoint_output_alarm_record_top");
    end
    $finish;
  end

endmodule

### filelist.f
sv/spoar_pkg.sv
sv/spoar_alarm.sv
sv/spoar_core.sv
sv/setpoint_output_alarm_record_top.sv
tb/tb_top.sv
